>>> rtl/ecsm_pkg.sv
`default_nettype none
package ecsm_pkg;

	// default field width
	localparam int FIELD_WIDTH_DEF = 32;

	// configuration register indexes
	localparam logic [1:0] REG_PRIME = 2'd0;
	localparam logic [1:0] REG_A     = 2'd1;
	localparam logic [1:0] REG_B     = 2'd2;

	// configuration reset values
	localparam int PRIME_RST = 23;
	localparam int A_RST     = 23;
	localparam int B_RST     = 10;

	// sequencer status toward the top level
	typedef struct packed {
		logic idle;
		logic done;
	} ecsm_stat_t;

endpackage
`default_nettype wire

>>> rtl/ecsm_modmul.sv
`default_nettype none
module ecsm_modmul import ecsm_pkg::*; #(
	parameter int W = FIELD_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [W-1:0] op_a,
	input  wire logic [W-1:0] op_b,
	input  wire logic [W-1:0] modulus,
	output logic              done,
	output logic [W-1:0]      prod
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  r_q, a_q, b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    dbl, sum;
	logic [W-1:0]  r2, nxt;

	// one multiplier bit per cycle: r = 2r (+a) mod p
	always_comb begin
		dbl = {r_q, 1'b0};
		if (dbl >= {1'b0, modulus})
			dbl = dbl - {1'b0, modulus};
		r2 = dbl[W-1:0];
		sum = {1'b0, r2} + {1'b0, a_q};
		if (sum >= {1'b0, modulus})
			sum = sum - {1'b0, modulus};
		nxt = b_q[W-1] ? sum[W-1:0] : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			a_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				r_q    <= '0;
				a_q    <= op_a;
				b_q    <= op_b;
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q   <= nxt;
				b_q   <= b_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = r_q;

endmodule
`default_nettype wire

>>> rtl/ecsm_core.sv
`default_nettype none
module ecsm_core import ecsm_pkg::*; #(
	parameter int W = FIELD_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] in_k,
	input  wire logic [W-1:0] in_x,
	input  wire logic [W-1:0] in_y,
	input  wire logic [W-1:0] prime,
	input  wire logic [W-1:0] coef_a,
	input  wire logic [W-1:0] coef_b,
	input  wire logic         take,
	output ecsm_stat_t        stat,
	output logic [W-1:0]      res_x,
	output logic [W-1:0]      res_y
);

	localparam int CW = $clog2(W + 1);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_MWAIT = 5'd1;
	localparam logic [4:0] ST_RK    = 5'd2;
	localparam logic [4:0] ST_RA    = 5'd3;
	localparam logic [4:0] ST_RB    = 5'd4;
	localparam logic [4:0] ST_RX    = 5'd5;
	localparam logic [4:0] ST_RY    = 5'd6;
	localparam logic [4:0] ST_C1    = 5'd7;
	localparam logic [4:0] ST_C2    = 5'd8;
	localparam logic [4:0] ST_C3    = 5'd9;
	localparam logic [4:0] ST_C4    = 5'd10;
	localparam logic [4:0] ST_C5    = 5'd11;
	localparam logic [4:0] ST_LINIT = 5'd12;
	localparam logic [4:0] ST_DBL   = 5'd13;
	localparam logic [4:0] ST_D1    = 5'd14;
	localparam logic [4:0] ST_D2    = 5'd15;
	localparam logic [4:0] ST_F1    = 5'd16;
	localparam logic [4:0] ST_F2    = 5'd17;
	localparam logic [4:0] ST_F3    = 5'd18;
	localparam logic [4:0] ST_ADDC  = 5'd19;
	localparam logic [4:0] ST_ADD   = 5'd20;
	localparam logic [4:0] ST_A1    = 5'd21;
	localparam logic [4:0] ST_NEXT  = 5'd22;
	localparam logic [4:0] ST_PSQ   = 5'd23;
	localparam logic [4:0] ST_PSQD  = 5'd24;
	localparam logic [4:0] ST_PMD   = 5'd25;
	localparam logic [4:0] ST_DONE  = 5'd26;

	function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] fsub(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W-1:0] d;
		d = x - y;
		if (x < y)
			d = d + m;
		return d;
	endfunction

	logic [4:0]    st_q, ret_q, pret_q;
	logic [W-1:0]  p_q, a_q, b_q, k_q, px_q, py_q, ax_q, ay_q, ux_q, uy_q;
	logic [W-1:0]  t_q, lam_q, s_q, e_q, pr_q, mop_a_q, mop_b_q;
	logic [CW-1:0] kcnt_q, ecnt_q;
	logic          go_q, in_add_q;
	logic          mdone;
	logic [W-1:0]  mres;
	logic [W-1:0]  t3, rx, root, nroot;

	ecsm_modmul #(.W(W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go_q),
		.op_a    (mop_a_q),
		.op_b    (mop_b_q),
		.modulus (p_q),
		.done    (mdone),
		.prod    (mres)
	);

	// small helpers for the current step
	always_comb begin
		t3    = fadd(fadd(mres, mres, p_q), mres, p_q);
		rx    = fsub(fsub(mres, ux_q, p_q), ax_q, p_q);
		root  = pr_q;
		nroot = (pr_q == '0) ? '0 : p_q - pr_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ret_q    <= ST_IDLE;
			pret_q   <= ST_IDLE;
			go_q     <= 1'b0;
			in_add_q <= 1'b0;
			kcnt_q   <= '0;
			ecnt_q   <= '0;
			p_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			k_q      <= '0;
			px_q     <= '0;
			py_q     <= '0;
			ax_q     <= '0;
			ay_q     <= '0;
			ux_q     <= '0;
			uy_q     <= '0;
			t_q      <= '0;
			lam_q    <= '0;
			s_q      <= '0;
			e_q      <= '0;
			pr_q     <= '0;
			mop_a_q  <= '0;
			mop_b_q  <= '0;
		end else begin
			go_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						p_q  <= prime;
						a_q  <= coef_a;
						b_q  <= coef_b;
						px_q <= in_x;
						py_q <= in_y;
						if (prime < W'(3)) begin
							ax_q <= in_x;
							ay_q <= in_y;
							st_q <= ST_DONE;
						end else begin
							mop_a_q <= W'(1);
							mop_b_q <= in_k;
							go_q    <= 1'b1;
							ret_q   <= ST_RK;
							st_q    <= ST_MWAIT;
						end
					end
				end
				ST_MWAIT: begin
					if (mdone)
						st_q <= ret_q;
				end
				// reduce inputs and coefficients mod p
				ST_RK: begin
					k_q <= mres;
					mop_a_q <= W'(1); mop_b_q <= a_q; go_q <= 1'b1;
					ret_q <= ST_RA; st_q <= ST_MWAIT;
				end
				ST_RA: begin
					a_q <= mres;
					mop_a_q <= W'(1); mop_b_q <= b_q; go_q <= 1'b1;
					ret_q <= ST_RB; st_q <= ST_MWAIT;
				end
				ST_RB: begin
					b_q <= mres;
					mop_a_q <= W'(1); mop_b_q <= px_q; go_q <= 1'b1;
					ret_q <= ST_RX; st_q <= ST_MWAIT;
				end
				ST_RX: begin
					px_q <= mres;
					mop_a_q <= W'(1); mop_b_q <= py_q; go_q <= 1'b1;
					ret_q <= ST_RY; st_q <= ST_MWAIT;
				end
				ST_RY: begin
					py_q <= mres;
					mop_a_q <= px_q; mop_b_q <= px_q; go_q <= 1'b1;
					ret_q <= ST_C1; st_q <= ST_MWAIT;
				end
				// curve check: s = x^3 + a*x + b
				ST_C1: begin
					mop_a_q <= mres; mop_b_q <= px_q; go_q <= 1'b1;
					ret_q <= ST_C2; st_q <= ST_MWAIT;
				end
				ST_C2: begin
					t_q <= mres;
					mop_a_q <= a_q; mop_b_q <= px_q; go_q <= 1'b1;
					ret_q <= ST_C3; st_q <= ST_MWAIT;
				end
				ST_C3: begin
					lam_q  <= fadd(fadd(t_q, mres, p_q), b_q, p_q);
					s_q    <= fadd(fadd(t_q, mres, p_q), b_q, p_q);
					e_q    <= (p_q - W'(1)) >> 1;
					pr_q   <= W'(1);
					ecnt_q <= CW'(W);
					pret_q <= ST_C4;
					st_q   <= ST_PSQ;
				end
				ST_C4: begin
					if (pr_q == W'(1)) begin
						s_q    <= lam_q;
						e_q    <= (p_q >> 2) + ((p_q[1:0] == 2'b11) ? W'(1) : W'(0));
						pr_q   <= W'(1);
						ecnt_q <= CW'(W);
						pret_q <= ST_C5;
						st_q   <= ST_PSQ;
					end else begin
						st_q <= ST_LINIT;
					end
				end
				ST_C5: begin
					if (py_q != root && py_q != nroot) begin
						ax_q <= px_q;
						ay_q <= py_q;
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_LINIT;
					end
				end
				ST_LINIT: begin
					ax_q     <= '0;
					ay_q     <= W'(1);
					kcnt_q   <= CW'(W);
					in_add_q <= 1'b0;
					st_q     <= ST_DBL;
				end
				// doubling of the accumulator
				ST_DBL: begin
					if (ax_q == '0 && ay_q == W'(1)) begin
						st_q <= in_add_q ? ST_NEXT : ST_ADDC;
					end else if (ay_q == '0) begin
						ax_q <= '0;
						ay_q <= W'(1);
						st_q <= in_add_q ? ST_NEXT : ST_ADDC;
					end else begin
						ux_q <= ax_q;
						uy_q <= ay_q;
						mop_a_q <= ax_q; mop_b_q <= ax_q; go_q <= 1'b1;
						ret_q <= ST_D1; st_q <= ST_MWAIT;
					end
				end
				ST_D1: begin
					t_q    <= fadd(t3, a_q, p_q);
					s_q    <= fadd(ay_q, ay_q, p_q);
					e_q    <= p_q - W'(2);
					pr_q   <= W'(1);
					ecnt_q <= CW'(W);
					pret_q <= ST_D2;
					st_q   <= ST_PSQ;
				end
				ST_D2, ST_A1: begin
					mop_a_q <= t_q; mop_b_q <= pr_q; go_q <= 1'b1;
					ret_q <= ST_F1; st_q <= ST_MWAIT;
				end
				// common tail: x3 = lam^2 - ux - ax, y3 = lam*(ux - x3) - uy
				ST_F1: begin
					lam_q <= mres;
					mop_a_q <= mres; mop_b_q <= mres; go_q <= 1'b1;
					ret_q <= ST_F2; st_q <= ST_MWAIT;
				end
				ST_F2: begin
					t_q <= rx;
					mop_a_q <= lam_q; mop_b_q <= fsub(ux_q, rx, p_q); go_q <= 1'b1;
					ret_q <= ST_F3; st_q <= ST_MWAIT;
				end
				ST_F3: begin
					ax_q <= t_q;
					ay_q <= fsub(mres, uy_q, p_q);
					st_q <= in_add_q ? ST_NEXT : ST_ADDC;
				end
				ST_ADDC: begin
					st_q <= k_q[W-1] ? ST_ADD : ST_NEXT;
				end
				// addition of the input point
				ST_ADD: begin
					in_add_q <= 1'b1;
					if (px_q == '0 && py_q == W'(1)) begin
						st_q <= ST_NEXT;
					end else if (ax_q == '0 && ay_q == W'(1)) begin
						ax_q <= px_q;
						ay_q <= py_q;
						st_q <= ST_NEXT;
					end else if (px_q == ax_q && py_q == ay_q) begin
						st_q <= ST_DBL;
					end else if (px_q == ax_q && fadd(py_q, ay_q, p_q) == '0) begin
						ax_q <= '0;
						ay_q <= W'(1);
						st_q <= ST_NEXT;
					end else begin
						ux_q   <= px_q;
						uy_q   <= py_q;
						t_q    <= fsub(ay_q, py_q, p_q);
						s_q    <= fsub(ax_q, px_q, p_q);
						e_q    <= p_q - W'(2);
						pr_q   <= W'(1);
						ecnt_q <= CW'(W);
						pret_q <= ST_A1;
						st_q   <= ST_PSQ;
					end
				end
				ST_NEXT: begin
					in_add_q <= 1'b0;
					k_q      <= k_q << 1;
					kcnt_q   <= kcnt_q - 1'b1;
					st_q     <= (kcnt_q == CW'(1)) ? ST_DONE : ST_DBL;
				end
				// exponentiation, exponent msb first
				ST_PSQ: begin
					if (ecnt_q == '0) begin
						st_q <= pret_q;
					end else begin
						mop_a_q <= pr_q; mop_b_q <= pr_q; go_q <= 1'b1;
						ret_q <= ST_PSQD; st_q <= ST_MWAIT;
					end
				end
				ST_PSQD: begin
					pr_q <= mres;
					if (e_q[W-1]) begin
						mop_a_q <= mres; mop_b_q <= s_q; go_q <= 1'b1;
						ret_q <= ST_PMD; st_q <= ST_MWAIT;
					end else begin
						e_q    <= e_q << 1;
						ecnt_q <= ecnt_q - 1'b1;
						st_q   <= ST_PSQ;
					end
				end
				ST_PMD: begin
					pr_q   <= mres;
					e_q    <= e_q << 1;
					ecnt_q <= ecnt_q - 1'b1;
					st_q   <= ST_PSQ;
				end
				ST_DONE: begin
					if (take)
						st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (st_q == ST_IDLE);
	assign stat.done = (st_q == ST_DONE);
	assign res_x     = ax_q;
	assign res_y     = ay_q;

endmodule
`default_nettype wire

>>> rtl/ec_point_scalar_multiply.sv
`default_nettype none
// operation: each modular product is computed in the bit-serial multiplier; reduction and
// curve check take 8 products and up to two modular powers, then each of the W scalar bits
// takes a doubling and, when the bit is set, an addition
// throughput: one item at a time; a finished result waits in the output register
// reset: configuration returns to p=23, a=23, b=10; no result is pending
module ec_point_scalar_multiply import ecsm_pkg::*; #(
	parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// scalar, point_x, point_y
	input  wire logic [((3*FIELD_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// result_x, result_y, at_infinity
	output logic [((2*FIELD_WIDTH+1+7)/8)*8-1:0]        m_tdata,
	input  wire logic                                   cfg_wen,
	input  wire logic [1:0]                             cfg_addr,
	input  wire logic [FIELD_WIDTH-1:0]                 cfg_wdata
);

	localparam int W  = FIELD_WIDTH;
	localparam int OW = ((2*FIELD_WIDTH+1+7)/8)*8;

	logic [W-1:0] p_q, a_q, b_q;
	logic [W-1:0] rx_q, ry_q, res_x, res_y;
	logic         inf_q, vld_q, out_free;
	ecsm_stat_t   stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= W'(PRIME_RST);
			a_q <= W'(A_RST);
			b_q <= W'(B_RST);
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_PRIME: p_q <= cfg_wdata;
				REG_A:     a_q <= cfg_wdata;
				REG_B:     b_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	ecsm_core #(.W(W)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_tvalid),
		.in_k   (s_tdata[W-1:0]),
		.in_x   (s_tdata[2*W-1:W]),
		.in_y   (s_tdata[3*W-1:2*W]),
		.prime  (p_q),
		.coef_a (a_q),
		.coef_b (b_q),
		.take   (out_free),
		.stat   (stat),
		.res_x  (res_x),
		.res_y  (res_y)
	);

	assign s_tready = stat.idle;
	assign out_free = !vld_q || m_tready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			rx_q  <= '0;
			ry_q  <= '0;
			inf_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= stat.done;
			if (stat.done) begin
				rx_q  <= res_x;
				ry_q  <= res_y;
				inf_q <= (res_x == '0) && (res_y == W'(1));
			end
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = OW'({inf_q, ry_q, rx_q});

endmodule
`default_nettype wire
